// File: hw/rtl/octahedral_normal_encoder_unit_macros.svh
// Assertion macros shared by the checker of the octahedral normal encoder.
// Depends on nothing; included by the checker file only.
`ifndef OCTAHEDRAL_NORMAL_ENCODER_UNIT_MACROS_SVH
`define OCTAHEDRAL_NORMAL_ENCODER_UNIT_MACROS_SVH

// Clocked assertion, switched off while reset is held low
`define OCTNE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset
`define OCTNE_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: hw/rtl/octne_pkg.sv
// Shared types and constants of the octahedral normal encoder.
// No dependencies; imported by the divider step and the top level.
package octne_pkg;

    // snorm16 result: 15 magnitude bits plus sign
    localparam int QBITS     = 15;
    localparam int HALF_BITS = 16;

    // Sideband that travels with each transaction through the divider
    typedef struct packed {
        logic neg_u;
        logic neg_v;
        logic zero;
    } t_side;

endpackage

// File: hw/rtl/octne_div_step.sv
// One registered restoring-division step for both lanes (u and v).
// Depends on octne_pkg for the quotient width and the sideband type.
module octne_div_step #(
    parameter int RW = 18
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [RW-1:0]                i_den,
    input  logic [RW-1:0]                i_rem_u,
    input  logic [octne_pkg::QBITS-1:0]  i_low_u,
    input  logic [RW-1:0]                i_rem_v,
    input  logic [octne_pkg::QBITS-1:0]  i_low_v,
    input  octne_pkg::t_side             i_side,
    output logic [RW-1:0]                o_den,
    output logic [RW-1:0]                o_rem_u,
    output logic [octne_pkg::QBITS-1:0]  o_low_u,
    output logic [RW-1:0]                o_rem_v,
    output logic [octne_pkg::QBITS-1:0]  o_low_v,
    output octne_pkg::t_side             o_side
);
    import octne_pkg::*;

    logic [RW:0]      w_t_u, w_t_v, w_d_u, w_d_v;
    logic             w_ge_u, w_ge_v;
    logic [RW-1:0]    n_rem_u, n_rem_v;
    logic [QBITS-1:0] n_low_u, n_low_v;

    // Shift in the next dividend bit, subtract the divisor when it fits.
    // The remainder stays below the divisor, so the result fits RW bits.
    always_comb begin
        w_t_u  = {i_rem_u, i_low_u[QBITS-1]};
        w_t_v  = {i_rem_v, i_low_v[QBITS-1]};
        w_d_u  = w_t_u - {1'b0, i_den};
        w_d_v  = w_t_v - {1'b0, i_den};
        w_ge_u = (w_t_u >= {1'b0, i_den});
        w_ge_v = (w_t_v >= {1'b0, i_den});
        n_rem_u = w_ge_u ? w_d_u[RW-1:0] : w_t_u[RW-1:0];
        n_rem_v = w_ge_v ? w_d_v[RW-1:0] : w_t_v[RW-1:0];
        // quotient bits fill in from the bottom as dividend bits leave the top
        n_low_u = {i_low_u[QBITS-2:0], w_ge_u};
        n_low_v = {i_low_v[QBITS-2:0], w_ge_v};
    end

    // Payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_den   <= i_den;
            o_rem_u <= n_rem_u;
            o_low_u <= n_low_u;
            o_rem_v <= n_rem_v;
            o_low_v <= n_low_v;
            o_side  <= i_side;
        end
    end

endmodule

// File: hw/rtl/octahedral_normal_encoder_unit.sv
// Octahedral normal encoder: signed 3-vector in, packed snorm16 (u, v) out.
// Depends on octne_pkg and octne_div_step.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one direction vector
//   i_comp_x, i_comp_y, i_comp_z per transaction, COMP_WIDTH bits each.
//   Output channel (o_valid / i_stall) carries o_packed_oct (u in bits
//   15:0, v in bits 31:16) and o_zero_vector for each transaction, in order.
//   A transaction moves when valid is high and stall is low at a clock edge.
// Pipeline: 20 register stages from the input to the output register:
//   4 front stages (abs, L1 sum, fold select, dividend build),
//   15 restoring-division stages, 1 output stage.
// Throughput: one transaction per cycle while the pipe is not stalled; set by
//   the pipelined divider: 15 chained quotient-bit stages, each for both lanes.
// Stall: each stage holds while it and every stage after it are full and
//   i_stall is high; empty stages keep filling, so bubbles are squeezed
//   out. o_stall rises only when the whole pipe is full and stalled.
// Reset: i_rst_n low on a clock edge clears all valid bits; no result
//   is pending afterward. Payload registers are not reset.
module octahedral_normal_encoder_unit #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COMP_WIDTH-1:0] i_comp_x,
    input  logic signed [COMP_WIDTH-1:0] i_comp_y,
    input  logic signed [COMP_WIDTH-1:0] i_comp_z,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [31:0]                  o_packed_oct,
    output logic                         o_zero_vector
);
    import octne_pkg::*;

    localparam int LW = COMP_WIDTH + 1;      // L1 norm width
    localparam int RW = LW + 1;              // divisor / remainder width
    localparam int NW = LW + HALF_BITS;      // dividend width
    localparam int NS = 4 + QBITS + 1;       // pipeline stages

    // Stage valid bits and per-stage load enables
    logic [NS:1] r_valid;
    logic [NS:1] w_vin;
    logic [NS:1] w_rdy;

    assign w_vin = {r_valid[NS-1:1], i_valid};

    genvar k;
    generate
        for (k = 1; k <= NS; k++) begin : g_ctl
            // a stage holds only when it and all stages after it are full
            assign w_rdy[k] = !(i_stall && (&r_valid[NS:k]));

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_valid[k] <= w_vin[k];
                end
            end
        end
    endgenerate

    assign o_stall = !w_rdy[1];
    assign o_valid = r_valid[NS];

    // Stage 1: magnitudes and signs
    logic [COMP_WIDTH-1:0] n1_ax, n1_ay, n1_az;
    logic [COMP_WIDTH-1:0] r1_ax, r1_ay, r1_az;
    logic                  r1_nx, r1_ny, r1_nz;

    always_comb begin
        n1_ax = i_comp_x[COMP_WIDTH-1] ? (~$unsigned(i_comp_x) + 1'b1) : $unsigned(i_comp_x);
        n1_ay = i_comp_y[COMP_WIDTH-1] ? (~$unsigned(i_comp_y) + 1'b1) : $unsigned(i_comp_y);
        n1_az = i_comp_z[COMP_WIDTH-1] ? (~$unsigned(i_comp_z) + 1'b1) : $unsigned(i_comp_z);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r1_ax <= n1_ax;
            r1_ay <= n1_ay;
            r1_az <= n1_az;
            r1_nx <= i_comp_x[COMP_WIDTH-1];
            r1_ny <= i_comp_y[COMP_WIDTH-1];
            r1_nz <= i_comp_z[COMP_WIDTH-1];
        end
    end

    // Stage 2: L1 norm and zero detect
    logic [LW-1:0] r2_l1, r2_ax, r2_ay;
    logic          r2_nx, r2_ny, r2_nz, r2_zero;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r2_l1   <= LW'(r1_ax) + LW'(r1_ay) + LW'(r1_az);
            r2_ax   <= LW'(r1_ax);
            r2_ay   <= LW'(r1_ay);
            r2_nx   <= r1_nx;
            r2_ny   <= r1_ny;
            r2_nz   <= r1_nz;
            r2_zero <= ~(|{r1_ax, r1_ay, r1_az});
        end
    end

    // Stage 3: numerators; lower hemisphere folds to L1 - |other|.
    // Sign of u follows x and sign of v follows y in both hemispheres.
    logic [LW-1:0] r3_num_u, r3_num_v, r3_l1;
    t_side         r3_side;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r3_num_u      <= r2_nz ? (r2_l1 - r2_ay) : r2_ax;
            r3_num_v      <= r2_nz ? (r2_l1 - r2_ax) : r2_ay;
            r3_l1         <= r2_l1;
            r3_side.neg_u <= r2_nx;
            r3_side.neg_v <= r2_ny;
            r3_side.zero  <= r2_zero;
        end
    end

    // Stage 4: dividend 65534*num + L1 over divisor 2*L1.
    // Dividend < 2^QBITS * divisor, so the top part is a valid first remainder.
    logic [NW-1:0] n4_big_u, n4_big_v;

    always_comb begin
        n4_big_u = {r3_num_u, {HALF_BITS{1'b0}}} - NW'({r3_num_u, 1'b0}) + NW'(r3_l1);
        n4_big_v = {r3_num_v, {HALF_BITS{1'b0}}} - NW'({r3_num_v, 1'b0}) + NW'(r3_l1);
    end

    logic [RW-1:0]    w_den   [0:QBITS];
    logic [RW-1:0]    w_rem_u [0:QBITS];
    logic [RW-1:0]    w_rem_v [0:QBITS];
    logic [QBITS-1:0] w_low_u [0:QBITS];
    logic [QBITS-1:0] w_low_v [0:QBITS];
    t_side            w_side  [0:QBITS];

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            w_den[0]   <= {r3_l1, 1'b0};
            w_rem_u[0] <= n4_big_u[NW-1:QBITS];
            w_low_u[0] <= n4_big_u[QBITS-1:0];
            w_rem_v[0] <= n4_big_v[NW-1:QBITS];
            w_low_v[0] <= n4_big_v[QBITS-1:0];
            w_side[0]  <= r3_side;
        end
    end

    // Stages 5 .. 4+QBITS: one quotient bit per stage for each lane
    generate
        for (k = 1; k <= QBITS; k++) begin : g_div
            octne_div_step #(
                .RW (RW)
            ) u_step (
                .i_clk   (i_clk),
                .i_en    (w_rdy[4+k]),
                .i_den   (w_den[k-1]),
                .i_rem_u (w_rem_u[k-1]),
                .i_low_u (w_low_u[k-1]),
                .i_rem_v (w_rem_v[k-1]),
                .i_low_v (w_low_v[k-1]),
                .i_side  (w_side[k-1]),
                .o_den   (w_den[k]),
                .o_rem_u (w_rem_u[k]),
                .o_low_u (w_low_u[k]),
                .o_rem_v (w_rem_v[k]),
                .o_low_v (w_low_v[k]),
                .o_side  (w_side[k])
            );
        end
    endgenerate

    // Output stage: apply sign and pack. The quotient never exceeds 32767
    // since num <= L1, so the 15-bit field is already the clamped value.
    logic [HALF_BITS-1:0] n_u, n_v;
    t_side                w_last;

    always_comb begin
        w_last = w_side[QBITS];
        n_u = {1'b0, w_low_u[QBITS]};
        n_v = {1'b0, w_low_v[QBITS]};
        if (w_last.neg_u) begin
            n_u = -n_u;
        end
        if (w_last.neg_v) begin
            n_v = -n_v;
        end
    end

    logic [31:0] r_packed;
    logic        r_zero;

    always_ff @(posedge i_clk) begin
        if (w_rdy[NS]) begin
            r_packed <= w_last.zero ? 32'd0 : {n_v, n_u};
            r_zero   <= w_last.zero;
        end
    end

    assign o_packed_oct  = r_packed;
    assign o_zero_vector = r_zero;

endmodule

// File: hw/rtl/octne_checker.sv
// Port-level checker for the octahedral normal encoder, bound to the top.
// Depends on octahedral_normal_encoder_unit_macros.svh.
`include "octahedral_normal_encoder_unit_macros.svh"

module octne_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_packed_oct,
    input logic        o_zero_vector
);

    // a held result keeps its payload
    `OCTNE_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_packed_oct) && $stable(o_zero_vector), "output changed while stalled")

    // input side backs up only when the whole pipe is full and stalled
    `OCTNE_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> o_valid && i_stall, "input stalled with room in the pipe")

    // zero vector gives an all-zero code
    `OCTNE_ASSERT(a_zero_code, i_clk, i_rst_n, o_valid && o_zero_vector |-> o_packed_oct == 32'd0, "zero vector with nonzero code")

    // clamped snorm16 halves never reach the most negative code
    `OCTNE_ASSERT(a_no_min_code, i_clk, i_rst_n, o_valid |-> o_packed_oct[15:0] != 16'h8000 && o_packed_oct[31:16] != 16'h8000, "snorm16 half out of range")

    // reset empties the pipe
    `OCTNE_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result pending after reset")

endmodule

bind octahedral_normal_encoder_unit octne_checker u_octne_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_packed_oct  (o_packed_oct),
    .o_zero_vector (o_zero_vector)
);

// File: test/tb_top.sv
// Self-checking testbench for octahedral_normal_encoder_unit.
// Drives direction vectors, predicts each packed snorm16 (u, v) word and the
// zero flag in-house, and checks results in order. Needs only the RTL.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = 16;
    localparam int SNORM_MAX   = 32767;
    localparam int PIPE_CYCLES = 20;
    localparam int HALF_PERIOD = 6;

    // Expected result of one transaction
    typedef struct {
        logic [31:0] oct_word;
        logic        zero_flag;
    } t_oct_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 i_stall = 1'b0;
    logic signed [CW-1:0] i_comp_x = '0;
    logic signed [CW-1:0] i_comp_y = '0;
    logic signed [CW-1:0] i_comp_z = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [31:0]          o_packed_oct;
    logic                 o_zero_vector;

    t_oct_result pending_oct_q[$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_request = 0;
    int          hold_left = 0;

    octahedral_normal_encoder_unit #(
        .COMP_WIDTH(CW)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_comp_x     (i_comp_x),
        .i_comp_y     (i_comp_y),
        .i_comp_z     (i_comp_z),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_packed_oct (o_packed_oct),
        .o_zero_vector(o_zero_vector)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // round(32767 * num / den), ties away from zero, clamped, then signed
    function automatic logic [15:0] snorm_quantize(longint unsigned num,
                                                   longint unsigned den,
                                                   bit neg);
        longint unsigned q;
        logic [15:0]     q16;
        q = (2 * SNORM_MAX * num + den) / (2 * den);
        if (q > SNORM_MAX)
            q = SNORM_MAX;
        q16 = q[15:0];
        return neg ? 16'(-q16) : q16;
    endfunction

    // Octahedral projection with lower-hemisphere fold
    function automatic t_oct_result oct_encode(logic signed [CW-1:0] x,
                                               logic signed [CW-1:0] y,
                                               logic signed [CW-1:0] z);
        t_oct_result     res;
        longint unsigned ax, ay, az, l1;
        logic [15:0]     u, v;
        ax = (x < 0) ? -longint'(x) : longint'(x);
        ay = (y < 0) ? -longint'(y) : longint'(y);
        az = (z < 0) ? -longint'(z) : longint'(z);
        l1 = ax + ay + az;
        if (l1 == 0) begin
            res.oct_word  = '0;
            res.zero_flag = 1'b1;
            return res;
        end
        if (z < 0) begin
            // folded: zero components count as positive
            u = snorm_quantize(l1 - ay, l1, x < 0);
            v = snorm_quantize(l1 - ax, l1, y < 0);
        end else begin
            u = snorm_quantize(ax, l1, x < 0);
            v = snorm_quantize(ay, l1, y < 0);
        end
        res.oct_word  = {v, u};
        res.zero_flag = 1'b0;
        return res;
    endfunction

    // Offer one vector; valid stays high until the transaction is accepted
    task automatic send_vector(input logic signed [CW-1:0] x,
                               input logic signed [CW-1:0] y,
                               input logic signed [CW-1:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_comp_x <= x;
        i_comp_y <= y;
        i_comp_z <= z;
        do @(posedge i_clk); while (o_stall);
        pending_oct_q = {pending_oct_q, oct_encode(x, y, z)};
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_oct_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Extremes, rounding ties, zero vector and fold sign cases
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_vector(0, 0, 0);
        send_vector(32767, 0, 0);
        send_vector(-32768, 0, 0);
        send_vector(0, 32767, 0);
        send_vector(0, -32768, 0);
        send_vector(0, 0, 32767);
        send_vector(0, 0, -32768);
        send_vector(-32768, -32768, -32768);
        send_vector(32767, 32767, 32767);
        send_vector(-32768, 32767, -32768);
        send_vector(32767, -32768, 1);
        // exact halves: 16383.5 rounds away from zero
        send_vector(1, 1, 0);
        send_vector(-1, -1, 0);
        send_vector(-1, 1, 0);
        // fold with zero x or y taking the positive sign
        send_vector(0, 5, -3);
        send_vector(5, 0, -3);
        send_vector(0, 0, -1);
        send_vector(-3, 0, -1);
        send_vector(0, -3, -1);
        send_vector(-7, -9, -2);
        send_vector(7, -9, -32768);
        send_vector(1, 0, 0);
        send_vector(0, 0, 1);
        send_vector(-1, -1, -1);
        wait_drained();
    endtask

    // Random vectors under one idling mix
    task automatic test_random(int n_items, int idle_pct, int stall_pct);
        logic signed [CW-1:0] v[3];
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_items) begin
            foreach (v[k]) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: v[k] = CW'($urandom);
                    6, 7:             v[k] = CW'($signed($urandom_range(8)) - 4);
                    8: begin
                        case ($urandom_range(5))
                            0: v[k] = -32768;
                            1: v[k] = -32767;
                            2: v[k] = -1;
                            3: v[k] = 1;
                            4: v[k] = 32767;
                            default: v[k] = 0;
                        endcase
                    end
                    default: v[k] = 0;
                endcase
            end
            send_vector(v[0], v[1], v[2]);
        end
        wait_drained();
    endtask

    // Long receiver hold fills the pipe; then a pause until it drains
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 80;
        repeat (45)
            send_vector(CW'($urandom), CW'($urandom), CW'($urandom));
        wait_drained();
        repeat (12)
            send_vector(CW'($urandom), CW'($urandom), CW'($urandom));
        wait_drained();
        repeat (12)
            send_vector(CW'($urandom), CW'($urandom), CW'($urandom));
        wait_drained();
    endtask

    // Receiver: long hold when requested, otherwise random stalls
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_oct_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_oct_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result packed_oct=%h zero_vector=%b",
                         $time, o_packed_oct, o_zero_vector);
            end else begin
                exp_res = pending_oct_q.pop_front();
                if (o_packed_oct !== exp_res.oct_word) begin
                    mismatch_count++;
                    $display("%0t: packed_oct expected %h actual %h",
                             $time, exp_res.oct_word, o_packed_oct);
                end
                if (o_zero_vector !== exp_res.zero_flag) begin
                    mismatch_count++;
                    $display("%0t: zero_vector expected %b actual %b",
                             $time, exp_res.zero_flag, o_zero_vector);
                end
            end
        end
    end

    // Main sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(310, 0, 0);
        test_random(350, 49, 0);
        test_random(350, 0, 49);
        test_random(350, 13, 13);
        test_backpressure();
        recv_stall_pct = 0;
        repeat (PIPE_CYCLES + 10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_oct_q.size() == 0) begin
            $display("octahedral_normal_encoder_unit regression: pass");
        end else begin
            $display("octahedral_normal_encoder_unit regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("octahedral_normal_encoder_unit regression: fail");
        $finish;
    end

endmodule
